// ----- rtl/core/sfr_pkg.sv -----
// Shared types and constants for the stream find-and-replace block.
package sfr_pkg;

  localparam int unsigned LEN_W  = 5;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned ADDR_W = 6;
  localparam int unsigned IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_PAT_LEN  = 3'd0;
  localparam logic [IDX_W-1:0] REG_PAT_LOW  = 3'd1;
  localparam logic [IDX_W-1:0] REG_PAT_HIGH = 3'd2;
  localparam logic [IDX_W-1:0] REG_REP_LEN  = 3'd3;
  localparam logic [IDX_W-1:0] REG_REP_LOW  = 3'd4;
  localparam logic [IDX_W-1:0] REG_REP_HIGH = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_REPLACE
  } state_e;

  typedef enum logic [2:0] {
    WIN_HOLD,
    WIN_PUSH,
    WIN_PUSH_POP,
    WIN_POP,
    WIN_CLEAR
  } win_op_e;

  typedef enum logic {
    OSEL_OLDEST,
    OSEL_REPL
  } out_sel_e;

  typedef struct packed {
    win_op_e  win_op;
    logic     out_load;
    out_sel_e out_sel;
    logic     out_last;
    logic     rep_start;
    logic     rep_step;
    logic     stop_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic in_last;
    logic at_len;
    logic over;
    logic match;
    logic acc_done;
    logic drain_done;
    logic rep_first_done;
    logic rep_done;
  } status_t;

endpackage

// ----- rtl/core/stream_find_replace.sv -----
// Streaming find-and-replace: top level joining registers, controller and datapath.
// An input's first result appears in the output register in the cycle after its acceptance.
// Input flow: a byte yielding at most one result frees the input unless the output stalls; a
//   byte yielding several stalls the input until its last result enters the single output register.
// Reset: window empty, controller idle, output invalid; lengths reset to 1, byte regs to 0.
module stream_find_replace import sfr_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned MAX_REPLACE = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        in_byte_i,
  input  logic              stream_end_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              run_last_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [LEN_W-1:0]    pat_len, rep_len;
  logic [2*DATA_W-1:0] pat_bytes, rep_bytes;
  cmd_t                cmd;
  status_t             status;

  sfr_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .pat_len_o   (pat_len),
    .pat_bytes_o (pat_bytes),
    .rep_len_o   (rep_len),
    .rep_bytes_o (rep_bytes)
  );

  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sfr_datapath #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_REPLACE (MAX_REPLACE)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_byte_i    (in_byte_i),
    .stream_end_i (stream_end_i),
    .pat_len_i    (pat_len),
    .pat_bytes_i  (pat_bytes),
    .rep_len_i    (rep_len),
    .rep_bytes_i  (rep_bytes),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o)
  );

endmodule

// ----- rtl/core/sfr_regs.sv -----
// Configuration register file behind the APB-style port.
module sfr_regs import sfr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready,
  output logic [LEN_W-1:0]     pat_len_o,
  output logic [2*DATA_W-1:0]  pat_bytes_o,
  output logic [LEN_W-1:0]     rep_len_o,
  output logic [2*DATA_W-1:0]  rep_bytes_o
);

  logic [LEN_W-1:0]  pat_len_q, rep_len_q;
  logic [DATA_W-1:0] pat_low_q, pat_high_q, rep_low_q, rep_high_q;
  logic [IDX_W-1:0]  reg_idx;
  logic              wr_en;

  assign reg_idx = paddr[ADDR_W-1:ADDR_W-IDX_W];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q  <= LEN_W'(1);
      pat_low_q  <= '0;
      pat_high_q <= '0;
      rep_len_q  <= LEN_W'(1);
      rep_low_q  <= '0;
      rep_high_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PAT_LEN:  pat_len_q  <= pwdata[LEN_W-1:0];
        REG_PAT_LOW:  pat_low_q  <= pwdata;
        REG_PAT_HIGH: pat_high_q <= pwdata;
        REG_REP_LEN:  rep_len_q  <= pwdata[LEN_W-1:0];
        REG_REP_LOW:  rep_low_q  <= pwdata;
        REG_REP_HIGH: rep_high_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PAT_LEN:  prdata = DATA_W'(pat_len_q);
      REG_PAT_LOW:  prdata = pat_low_q;
      REG_PAT_HIGH: prdata = pat_high_q;
      REG_REP_LEN:  prdata = DATA_W'(rep_len_q);
      REG_REP_LOW:  prdata = rep_low_q;
      REG_REP_HIGH: prdata = rep_high_q;
      default:      prdata = '0;
    endcase
  end

  assign pat_len_o   = pat_len_q;
  assign pat_bytes_o = {pat_high_q, pat_low_q};
  assign rep_len_o   = rep_len_q;
  assign rep_bytes_o = {rep_high_q, rep_low_q};

endmodule

// ----- rtl/core/sfr_datapath.sv -----
// Datapath: byte window, pattern compare, replacement index and output register.
module sfr_datapath import sfr_pkg::*; #(
  parameter int unsigned MAX_PATTERN = 16,
  parameter int unsigned MAX_REPLACE = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          in_byte_i,
  input  logic                stream_end_i,
  input  logic [LEN_W-1:0]    pat_len_i,
  input  logic [2*DATA_W-1:0] pat_bytes_i,
  input  logic [LEN_W-1:0]    rep_len_i,
  input  logic [2*DATA_W-1:0] rep_bytes_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [7:0]          out_byte_o,
  output logic                run_last_o
);

  localparam int unsigned FW  = $clog2(MAX_PATTERN + 1);
  localparam int unsigned RLW = $clog2(MAX_REPLACE + 1);
  localparam int unsigned RIW = (MAX_REPLACE > 1) ? $clog2(MAX_REPLACE) : 1;

  logic [7:0]     win_q [MAX_PATTERN];
  logic [7:0]     win_d [MAX_PATTERN];
  logic [7:0]     shifted [MAX_PATTERN];
  logic [FW-1:0]  fill_q, fill_d, fill_m1;
  logic [FW-1:0]  stop_q, stop_d, stop_in;
  logic [FW-1:0]  plen, plen_m1;
  logic [RLW-1:0] rlen, rlen_m1;
  logic [RIW-1:0] rep_idx_q, rep_idx_d, rep_sel;
  logic [MAX_PATTERN-1:0] lane_ok;
  logic [7:0]     cand;
  logic [7:0]     oldest, repl_byte, out_byte_d;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     out_byte_q;
  logic           run_last_q, run_last_d;
  logic           out_free;

  // lengths of 0 act as 1, lengths above the maximum saturate
  assign plen = (pat_len_i == '0) ? FW'(1) :
                (pat_len_i > LEN_W'(MAX_PATTERN)) ? FW'(MAX_PATTERN) : FW'(pat_len_i);
  assign rlen = (rep_len_i == '0) ? RLW'(1) :
                (rep_len_i > LEN_W'(MAX_REPLACE)) ? RLW'(MAX_REPLACE) : RLW'(rep_len_i);
  assign plen_m1 = plen - FW'(1);
  assign rlen_m1 = rlen - RLW'(1);
  assign fill_m1 = fill_q - FW'(1);

  // compare window plus incoming byte against the pattern, lane by lane
  always_comb begin
    cand = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      cand       = (FW'(i) == fill_q) ? in_byte_i : win_q[i];
      lane_ok[i] = (FW'(i) >= plen) || (cand == pat_bytes_i[8*i +: 8]);
    end
  end

  always_comb begin
    shifted[MAX_PATTERN-1] = win_q[MAX_PATTERN-1];
    for (int i = 0; i < MAX_PATTERN - 1; i++) begin
      shifted[i] = win_q[i+1];
    end
  end

  always_comb begin
    fill_d = fill_q;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_d[i] = win_q[i];
    end
    unique case (cmd_i.win_op)
      WIN_HOLD: ;
      WIN_PUSH: begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
          if (FW'(i) == fill_q) win_d[i] = in_byte_i;
        end
        fill_d = fill_q + FW'(1);
      end
      WIN_PUSH_POP: begin
        // oldest leaves, new byte lands at the tail; fill is unchanged
        for (int i = 0; i < MAX_PATTERN; i++) begin
          win_d[i] = (FW'(i) == fill_m1) ? in_byte_i : shifted[i];
        end
      end
      WIN_POP: begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
          win_d[i] = shifted[i];
        end
        fill_d = fill_m1;
      end
      WIN_CLEAR: fill_d = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_q[i] <= win_d[i];
    end
  end

  assign stop_in = stream_end_i ? '0 : plen_m1;
  assign stop_d  = cmd_i.stop_load ? stop_in : stop_q;

  assign rep_sel   = cmd_i.rep_start ? '0 : rep_idx_q;
  assign rep_idx_d = (cmd_i.rep_start || cmd_i.rep_step) ? rep_sel + RIW'(1) : rep_idx_q;
  assign repl_byte = rep_bytes_i[{4'(rep_sel), 3'b000} +: 8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      stop_q    <= '0;
      rep_idx_q <= '0;
    end else begin
      fill_q    <= fill_d;
      stop_q    <= stop_d;
      rep_idx_q <= rep_idx_d;
    end
  end

  // output register
  assign out_free   = !out_valid_q || !out_stall_i;
  assign oldest     = (fill_q == '0) ? in_byte_i : win_q[0];
  assign out_byte_d = (cmd_i.out_sel == OSEL_REPL) ? repl_byte : oldest;

  always_comb begin
    out_valid_d = out_valid_q;
    run_last_d  = run_last_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      run_last_d  = cmd_i.out_last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      run_last_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      run_last_q  <= run_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_byte_q <= out_byte_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_last_o  = run_last_q;

  assign status_o.out_free       = out_free;
  assign status_o.in_last        = stream_end_i;
  assign status_o.at_len         = (fill_q == plen_m1);
  assign status_o.over           = (fill_q > plen_m1);
  assign status_o.match          = &lane_ok;
  assign status_o.acc_done       = (fill_q == stop_in);
  assign status_o.drain_done     = (fill_q == stop_q + FW'(1));
  assign status_o.rep_first_done = (rlen == RLW'(1));
  assign status_o.rep_done       = (RLW'(rep_idx_q) == rlen_m1);

endmodule

// ----- rtl/core/sfr_ctrl.sv -----
// Controller: accepts input transactions and sequences drain and replacement bursts.
module sfr_ctrl import sfr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   accept, acc_match, acc_pop;

  assign accept    = in_valid_i && (state_q == ST_IDLE) && status_i.out_free;
  assign acc_match = accept && status_i.at_len && status_i.match;
  // mismatch at full length, window over length, or stream end all pop the oldest
  assign acc_pop   = accept && !acc_match &&
                     (status_i.at_len || status_i.over || status_i.in_last);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc_match && !status_i.rep_first_done) state_d = ST_REPLACE;
        else if (acc_pop && !status_i.acc_done)     state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status_i.out_free && status_i.drain_done) state_d = ST_IDLE;
      end
      ST_REPLACE: begin
        if (status_i.out_free && status_i.rep_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.win_op  = WIN_HOLD;
    cmd_o.out_sel = OSEL_OLDEST;
    in_stall_o = !((state_q == ST_IDLE) && status_i.out_free);
    unique case (state_q)
      ST_IDLE: begin
        if (acc_match) begin
          cmd_o.win_op    = WIN_CLEAR;
          cmd_o.out_load  = 1'b1;
          cmd_o.out_sel   = OSEL_REPL;
          cmd_o.rep_start = 1'b1;
          cmd_o.out_last  = status_i.rep_first_done;
        end else if (acc_pop) begin
          cmd_o.win_op    = WIN_PUSH_POP;
          cmd_o.out_load  = 1'b1;
          cmd_o.stop_load = 1'b1;
          cmd_o.out_last  = status_i.acc_done;
        end else if (accept) begin
          cmd_o.win_op    = WIN_PUSH;
        end
      end
      ST_DRAIN: begin
        if (status_i.out_free) begin
          cmd_o.win_op   = WIN_POP;
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = status_i.drain_done;
        end
      end
      ST_REPLACE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OSEL_REPL;
          cmd_o.rep_step = 1'b1;
          cmd_o.out_last = status_i.rep_done;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

endmodule
